FILE: sv/rotated_bit_correlation_counter_assert.svh
// Assertion macros for the rotated bit correlation counter.
// Used by the top level; no other dependencies.
`ifndef ROTATED_BIT_CORRELATION_COUNTER_ASSERT_SVH
`define ROTATED_BIT_CORRELATION_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RBCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RBCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rbcc_pkg.sv
// Shared types and constants for the rotated bit correlation counter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbcc_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int FUNC_COUNT    = 5;
    localparam int COUNT_W       = 32;
    localparam int SEL_W         = 6;
    localparam int FSEL_W        = 3;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    typedef enum logic [FSEL_W-1:0] {
        F_AND    = 3'd0,
        F_ANDN_B = 3'd1,
        F_ANDN_A = 3'd2,
        F_XOR    = 3'd3,
        F_OR     = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REC,
        S_RSEL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: sv/rbcc_if.sv
// Valid/ready channel interfaces for the rotated bit correlation counter.
// Depends on rbcc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rbcc_in_if import rbcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [63:0]       a_word;
    logic [63:0]       b_word;
    logic [SEL_W-1:0]  rotation_sel;
    logic [SEL_W-1:0]  bit_sel;
    logic [FSEL_W-1:0] function_sel;

    modport source (
        output valid, opcode, a_word, b_word, rotation_sel, bit_sel, function_sel,
        input  ready
    );
    modport sink (
        input  valid, opcode, a_word, b_word, rotation_sel, bit_sel, function_sel,
        output ready
    );
endinterface

interface rbcc_out_if import rbcc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] count_value;
    logic               was_read;

    modport source (
        output valid, count_value, was_read,
        input  ready
    );
    modport sink (
        input  valid, count_value, was_read,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/rotated_bit_correlation_counter.sv
// Top level of the rotated bit correlation counter: sequencer, row memory, row adder.
// Depends on rbcc_pkg, rbcc_if and rotated_bit_correlation_counter_assert.svh.
//
// Use: items arrive on i_in (valid/ready). A record item (opcode 0) adds the five
// bitwise functions of (a rotated left by r, b) into the counters of every rotation r.
// A read item (opcode 1) returns one counter, addressed by rotation, bit and function.
// Each item gives one result on o_out: the counter for a read, zero after a record.
// Counters sit in a memory of WORD_BITS rows, one row per rotation holding
// WORD_BITS*5 counters; one shared row adder does a read-modify-write of one row
// per cycle. A record passes through the row loop and then the done state; a read
// passes through the read-select state and then the done state, which loads the
// result into the output register. i_in.ready is high only while the sequencer
// is idle, so items go one at a time, each leaving the done state before the next is taken.
// Reset clears a valid bit per row; a row never written reads as zero, so the
// block takes items in the first cycle after reset. A stalled o_out holds its
// result; the next item may be accepted meanwhile, and its result waits in the
// done state until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "rotated_bit_correlation_counter_assert.svh"

module rotated_bit_correlation_counter import rbcc_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rbcc_in_if.sink     i_in,
    rbcc_out_if.source  o_out
);

    localparam int ROT_W  = $clog2(WORD_BITS);
    localparam int CNT_W  = $clog2(WORD_BITS + 1);
    localparam int LANES  = WORD_BITS * FUNC_COUNT;
    localparam int LANE_W = $clog2(LANES);
    localparam int ROW_W  = LANES * COUNT_W;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_pend;
    logic [ROT_W-1:0]     r_wr_addr;
    logic [WORD_BITS-1:0] r_a, r_b;
    logic [LANE_W-1:0]    r_lane;
    logic                 r_rd_ok;
    logic [ROW_W-1:0]     r_row_q;
    logic                 r_row_v;
    logic [WORD_BITS-1:0] r_valid;
    logic [COUNT_W-1:0]   r_res;
    logic                 r_res_read;
    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_out_count;
    logic                 r_out_read;

    logic [ROW_W-1:0]     r_mem [WORD_BITS];

    logic                 in_ready, accept, mem_re, mem_we, out_load, rec_last;
    logic [ROT_W-1:0]     rd_addr;
    logic [ROW_W-1:0]     row_eff, n_row;
    logic [WORD_BITS-1:0] fn [FUNC_COUNT];
    logic                 n_rd_ok;
    logic [LANE_W-1:0]    n_lane;

    assign accept   = i_in.valid && in_ready;
    assign rec_last = r_pend && (r_wr_addr == ROT_W'(WORD_BITS - 1));
    assign row_eff  = r_row_v ? r_row_q : '0;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (t_opcode'(i_in.opcode) == OP_READ) ? S_RSEL : S_REC;
                end
            end
            S_REC: begin
                if (rec_last) begin
                    n_state = S_DONE;
                end
            end
            S_RSEL:  n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready = 1'b0;
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        rd_addr  = '0;
        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                mem_re   = i_in.valid && (t_opcode'(i_in.opcode) == OP_READ);
                rd_addr  = i_in.rotation_sel[ROT_W-1:0];
            end
            S_REC: begin
                mem_re  = (r_cnt < CNT_W'(WORD_BITS));
                rd_addr = r_cnt[ROT_W-1:0];
                mem_we  = r_pend;
            end
            S_RSEL: ;
            S_DONE:  out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    // Bit functions of the current rotation
    always_comb begin
        fn[F_AND]    = r_a & r_b;
        fn[F_ANDN_B] = r_a & ~r_b;
        fn[F_ANDN_A] = ~r_a & r_b;
        fn[F_XOR]    = r_a ^ r_b;
        fn[F_OR]     = r_a | r_b;
    end

    // Shared row adder: one increment per counter lane
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            for (int k = 0; k < FUNC_COUNT; k++) begin
                n_row[(j*FUNC_COUNT + k)*COUNT_W +: COUNT_W] =
                    row_eff[(j*FUNC_COUNT + k)*COUNT_W +: COUNT_W] +
                    COUNT_W'(fn[k][j]);
            end
        end
    end

    // Read address decode
    always_comb begin
        n_rd_ok = (32'(i_in.rotation_sel) < WORD_BITS) &&
                  (32'(i_in.bit_sel) < WORD_BITS) &&
                  (i_in.function_sel <= F_OR);
        n_lane  = '0;
        if (n_rd_ok) begin
            n_lane = LANE_W'(i_in.bit_sel[ROT_W-1:0]) * LANE_W'(FUNC_COUNT) +
                     LANE_W'(i_in.function_sel);
        end
    end

    // Row memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_addr] <= n_row;
        end
        if (mem_re) begin
            r_row_q <= r_mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end else if (r_state == S_REC) begin
                if (mem_re) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                r_pend <= mem_re;
            end
            if (mem_we) begin
                r_valid[r_wr_addr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_row_v   <= r_valid[rd_addr];
            r_wr_addr <= rd_addr;
        end
        if (accept) begin
            r_a     <= i_in.a_word[WORD_BITS-1:0];
            r_b     <= i_in.b_word[WORD_BITS-1:0];
            r_lane  <= n_lane;
            r_rd_ok <= n_rd_ok;
        end else if (mem_we) begin
            r_a <= {r_a[WORD_BITS-2:0], r_a[WORD_BITS-1]};
        end
        if (rec_last && r_state == S_REC) begin
            r_res      <= '0;
            r_res_read <= 1'b0;
        end else if (r_state == S_RSEL) begin
            r_res      <= r_rd_ok ? row_eff[r_lane*COUNT_W +: COUNT_W] : '0;
            r_res_read <= 1'b1;
        end
        if (out_load) begin
            r_out_count <= r_res;
            r_out_read  <= r_res_read;
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.count_value = r_out_count;
    assign o_out.was_read    = r_out_read;

    `RBCC_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != S_IDLE, "item accepted but sequencer stayed idle")
    `RBCC_ASSERT_NEXT(a_record_done, i_clk, i_rst_n, (r_state == S_REC) && rec_last, (r_state == S_DONE) && !r_res_read && (r_res == '0), "record finished without a zero result")
    `RBCC_ASSERT_NOW(a_no_read_past_end, i_clk, i_rst_n, (r_state == S_REC) && (r_cnt == CNT_W'(WORD_BITS)), !mem_re, "row read issued past the last rotation")
    `RBCC_ASSERT_NOW(a_write_in_loop, i_clk, i_rst_n, mem_we, (r_state == S_REC) && r_pend, "row write outside the record loop")

endmodule

`default_nettype wire
